// ===== rtl/dcdm_pkg.sv =====
// ============================================================================
// dcdm_pkg: shared constants, types and helpers of the dominant colour map
// Histogram geometry, queue sizing, operation codes and the queue entry type.
// ============================================================================
package dcdm_pkg;

    localparam int BIN_SHIFT   = 2;
    localparam int COUNT_BITS  = 16;
    localparam int CHAN_BITS   = 5;
    localparam int AXIS_BITS   = CHAN_BITS - BIN_SHIFT;
    localparam int BIN_BITS    = 3 * AXIS_BITS;
    localparam int BIN_COUNT   = 1 << BIN_BITS;
    localparam int DIST_BITS   = 7;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_DEPTH = 1 << QUEUE_AW;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [CHAN_BITS-1:0]  CHAN_MAX  = 5'h1F;
    localparam logic [DIST_BITS-1:0]  DIST_MAX  = 7'd93;

    localparam logic FUNC_ACC = 1'b0;
    localparam logic FUNC_MAP = 1'b1;

    typedef struct packed {
        logic                 func;
        logic                 last;
        logic [CHAN_BITS-1:0] r;
        logic [CHAN_BITS-1:0] g;
        logic [CHAN_BITS-1:0] b;
    } t_op;

    function automatic logic [CHAN_BITS-1:0] abs_diff(input logic [CHAN_BITS-1:0] a,
                                                      input logic [CHAN_BITS-1:0] b);
        abs_diff = (a > b) ? (a - b) : (b - a);
    endfunction

endpackage

// ===== rtl/dcdm_front.sv =====
// ============================================================================
// dcdm_front: pixel intake and decode
// Swaps the pixel bytes, splits the colour channels, clamps red and pushes
// one operation per accepted beat into the queue.
// ============================================================================
module dcdm_front (
    input  logic          i_valid,
    output logic          o_ready,
    input  logic          i_func,
    input  logic [15:0]   i_pixel,
    input  logic          i_last,
    input  logic          i_full,
    output logic          o_push,
    output dcdm_pkg::t_op o_op
);
    import dcdm_pkg::*;

    logic [15:0] swapped;
    logic [5:0]  red_raw;

    assign swapped = {i_pixel[7:0], i_pixel[15:8]};
    assign red_raw = swapped[10:5];

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_op.func = i_func;
        o_op.last = i_last;
        o_op.b    = swapped[15:11];
        // Red has six bits in the word but only five are meaningful.
        o_op.r    = red_raw[5] ? CHAN_MAX : red_raw[CHAN_BITS-1:0];
        o_op.g    = swapped[4:0];
    end

endmodule

// ===== rtl/dcdm_queue.sv =====
// ============================================================================
// dcdm_queue: short operation queue
// Decouples pixel intake from histogram and distance processing.
// ============================================================================
module dcdm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  dcdm_pkg::t_op i_data,
    output logic          o_full,
    output logic          o_valid,
    output dcdm_pkg::t_op o_data,
    input  logic          i_pop
);
    import dcdm_pkg::*;

    t_op                 r_entry [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_entry[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== rtl/dcdm_back.sv =====
// ============================================================================
// dcdm_back: histogram update, dominant bin scan and distance output
// Runs the histogram read-modify-write pipeline, the bin scan, the clearing
// sweep and the registered distance output.
// ============================================================================
module dcdm_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_op_valid,
    input  dcdm_pkg::t_op                 i_op,
    output logic                          o_op_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [dcdm_pkg::DIST_BITS-1:0] o_distance
);
    import dcdm_pkg::*;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;

    logic [COUNT_BITS-1:0] mem [BIN_COUNT];

    logic [1:0]            r_state,    n_state;
    logic [BIN_BITS:0]     r_cnt,      n_cnt;
    logic                  r_s2_vld,   n_s2_vld;
    logic [BIN_BITS-1:0]   r_s2_addr,  n_s2_addr;
    logic                  r_s2_last,  n_s2_last;
    logic                  r_fwd_vld,  n_fwd_vld;
    logic [BIN_BITS-1:0]   r_fwd_addr, n_fwd_addr;
    logic [COUNT_BITS-1:0] r_fwd_data, n_fwd_data;
    logic                  r_scan_vld, n_scan_vld;
    logic [BIN_BITS-1:0]   r_scan_idx, n_scan_idx;
    logic [COUNT_BITS-1:0] r_best,     n_best;
    logic [BIN_BITS-1:0]   r_best_idx, n_best_idx;
    logic                  r_o_valid,  n_o_valid;
    logic [DIST_BITS-1:0]  r_o_dist,   n_o_dist;
    logic [COUNT_BITS-1:0] r_rd_data;

    logic                  out_free;
    logic                  pop;
    logic                  acc_pop;
    logic                  map_pop;
    logic [BIN_BITS-1:0]   op_bin;
    logic                  rd_en;
    logic [BIN_BITS-1:0]   rd_addr;
    logic                  mem_we;
    logic [BIN_BITS-1:0]   wr_addr;
    logic [COUNT_BITS-1:0] wr_data;
    logic [COUNT_BITS-1:0] s2_cur;
    logic [COUNT_BITS-1:0] s2_next;
    logic [CHAN_BITS-1:0]  base_r, base_g, base_b;
    logic [DIST_BITS-1:0]  map_dist;

    assign op_bin = {i_op.r[CHAN_BITS-1 -: AXIS_BITS],
                     i_op.g[CHAN_BITS-1 -: AXIS_BITS],
                     i_op.b[CHAN_BITS-1 -: AXIS_BITS]};

    // The dominant bin is simply the best index of the latest scan.
    assign base_r = {r_best_idx[BIN_BITS-1 -: AXIS_BITS], {BIN_SHIFT{1'b0}}};
    assign base_g = {r_best_idx[2*AXIS_BITS-1 -: AXIS_BITS], {BIN_SHIFT{1'b0}}};
    assign base_b = {r_best_idx[AXIS_BITS-1:0], {BIN_SHIFT{1'b0}}};

    assign map_dist = DIST_BITS'(abs_diff(base_r, i_op.r))
                    + DIST_BITS'(abs_diff(base_g, i_op.g))
                    + DIST_BITS'(abs_diff(base_b, i_op.b));

    assign out_free = !r_o_valid || i_ready;
    // Hold further pops while the last accumulate beat is still being written.
    assign pop      = i_op_valid && (r_state == S_RUN) && !(r_s2_vld && r_s2_last)
                   && ((i_op.func == FUNC_ACC) || out_free);
    assign acc_pop  = pop && (i_op.func == FUNC_ACC);
    assign map_pop  = pop && (i_op.func == FUNC_MAP);
    assign o_op_pop = pop;

    assign rd_en   = acc_pop || ((r_state == S_SCAN) && !r_cnt[BIN_BITS]);
    assign rd_addr = (r_state == S_SCAN) ? r_cnt[BIN_BITS-1:0] : op_bin;

    // A read issued in the same cycle as a write to the same bin sees the old
    // count, so the value written last cycle is forwarded.
    assign s2_cur  = (r_fwd_vld && (r_fwd_addr == r_s2_addr)) ? r_fwd_data : r_rd_data;
    assign s2_next = (s2_cur == COUNT_MAX) ? s2_cur : s2_cur + 1'b1;

    assign mem_we  = r_s2_vld || (r_state == S_CLEAR);
    assign wr_addr = r_s2_vld ? r_s2_addr : r_cnt[BIN_BITS-1:0];
    assign wr_data = r_s2_vld ? s2_next : '0;

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_s2_vld   = acc_pop;
        n_s2_addr  = acc_pop ? op_bin : r_s2_addr;
        n_s2_last  = acc_pop ? i_op.last : r_s2_last;
        n_fwd_vld  = r_s2_vld && acc_pop;
        n_fwd_addr = r_s2_addr;
        n_fwd_data = s2_next;
        n_scan_vld = 1'b0;
        n_scan_idx = r_scan_idx;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_o_valid  = r_o_valid;
        n_o_dist   = r_o_dist;

        if (map_pop) begin
            n_o_valid = 1'b1;
            n_o_dist  = map_dist;
        end else if (i_ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt[BIN_BITS-1:0] == '1) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (r_s2_vld && r_s2_last) begin
                    n_state    = S_SCAN;
                    n_cnt      = '0;
                    n_best     = '0;
                    n_best_idx = '0;
                end else if (map_pop && i_op.last) begin
                    n_state = S_CLEAR;
                    n_cnt   = '0;
                end
            end
            S_SCAN: begin
                if (!r_cnt[BIN_BITS]) begin
                    n_cnt      = r_cnt + 1'b1;
                    n_scan_vld = 1'b1;
                    n_scan_idx = r_cnt[BIN_BITS-1:0];
                end else if (!r_scan_vld) begin
                    n_state = S_RUN;
                end
                // Strictly greater keeps the first bin among equal counts.
                if (r_scan_vld && (r_rd_data > r_best)) begin
                    n_best     = r_rd_data;
                    n_best_idx = r_scan_idx;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_cnt   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_cnt      <= '0;
            r_s2_vld   <= 1'b0;
            r_fwd_vld  <= 1'b0;
            r_scan_vld <= 1'b0;
            r_best_idx <= '0;
            r_o_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_s2_vld   <= n_s2_vld;
            r_fwd_vld  <= n_fwd_vld;
            r_scan_vld <= n_scan_vld;
            r_best_idx <= n_best_idx;
            r_o_valid  <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_addr  <= n_s2_addr;
        r_s2_last  <= n_s2_last;
        r_fwd_addr <= n_fwd_addr;
        r_fwd_data <= n_fwd_data;
        r_scan_idx <= n_scan_idx;
        r_best     <= n_best;
        r_o_dist   <= n_o_dist;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_valid    = r_o_valid;
    assign o_distance = r_o_dist;

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !mem_we)
        else $error("histogram written during scan");

    a_pop_only_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (r_state == S_RUN))
        else $error("queue popped outside run state");

    a_last_acc_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && r_s2_last) |=> (r_state == S_SCAN))
        else $error("last accumulate beat did not start a scan");

    a_distance_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_dist <= DIST_MAX))
        else $error("distance out of range");

endmodule

// ===== rtl/dominant_color_distance_map.sv =====
// ============================================================================
// dominant_color_distance_map: two-pass dominant colour distance mapper
// Builds an 8x8x8 colour histogram of a frame, picks the dominant bin and
// maps each pixel of the second pass to its distance from that bin's colour.
// ============================================================================
//
//   Channel   Direction   Handshake            Payload
//   input     in          i_valid / o_ready    i_func, i_pixel, i_last
//   output    out         o_valid / i_ready    o_distance
//
// One beat per cycle is taken in both passes while the queue has room.
// The last accumulate beat starts a scan of all 512 bins; no beat leaves the
// queue until the scan is over, since the memory has a single read port.
// After reset, and after the last map beat, a clearing sweep writes the
// 512 bins one per cycle; the queue still fills but nothing is processed.
// A stalled output holds map beats in the queue; accumulate beats carry on.
module dominant_color_distance_map (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_func,
    input  logic [15:0]                    i_pixel,
    input  logic                           i_last,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [dcdm_pkg::DIST_BITS-1:0] o_distance
);
    import dcdm_pkg::*;

    logic push;
    logic full;
    logic q_valid;
    logic q_pop;
    t_op  push_op;
    t_op  q_op;

    dcdm_front u_front (
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_func  (i_func),
        .i_pixel (i_pixel),
        .i_last  (i_last),
        .i_full  (full),
        .o_push  (push),
        .o_op    (push_op)
    );

    dcdm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_op),
        .o_full  (full),
        .o_valid (q_valid),
        .o_data  (q_op),
        .i_pop   (q_pop)
    );

    dcdm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (q_valid),
        .i_op       (q_op),
        .o_op_pop   (q_pop),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_distance (o_distance)
    );

endmodule

// ===== tb/dominant_color_distance_map_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Dominant colour distance map regression
// Streams accumulate and map passes into the block with random sender bursts
// and receiver stalls. A predictor keeps its own histogram and dominant bin,
// and every distance beat is checked against the oldest prediction.
// ----------------------------------------------------------------------------
module dominant_color_distance_map_test;
    import dcdm_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 1200;
    localparam int RANDOM_BEATS = 1750;
    localparam int HOLD_CYCLES  = 1000;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic                 i_func;
    logic [15:0]          i_pixel;
    logic                 i_last;
    logic                 o_valid;
    logic                 i_ready;
    logic [DIST_BITS-1:0] o_distance;

    dominant_color_distance_map i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_func     (i_func),
        .i_pixel    (i_pixel),
        .i_last     (i_last),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_distance (o_distance)
    );

    class distance_predictor;
        bit [COUNT_BITS-1:0]  bin_count [BIN_COUNT];
        int unsigned          dom_r, dom_g, dom_b;
        bit [DIST_BITS-1:0]   expected_distance_q [$];

        function new();
            clear_counts();
            dom_r = 0;
            dom_g = 0;
            dom_b = 0;
        endfunction

        function void clear_counts();
            foreach (bin_count[i]) bin_count[i] = '0;
        endfunction

        function int unsigned chan_gap(int unsigned a, int unsigned b);
            return (a > b) ? a - b : b - a;
        endfunction

        function int pending();
            return expected_distance_q.size();
        endfunction

        function void note_beat(logic func, logic [15:0] pixel, logic last);
            logic [15:0] swapped;
            logic [5:0]  r_raw;
            int unsigned r, g, b, idx, pix_dist, best, dom_bin;
            swapped = {pixel[7:0], pixel[15:8]};
            r_raw   = swapped[10:5];
            r = (r_raw > CHAN_MAX) ? CHAN_MAX : r_raw;
            g = swapped[4:0];
            b = swapped[15:11];
            if (func == FUNC_ACC) begin
                idx = ((r >> BIN_SHIFT) << (2 * AXIS_BITS))
                    | ((g >> BIN_SHIFT) << AXIS_BITS)
                    | (b >> BIN_SHIFT);
                if (bin_count[idx] != COUNT_MAX) bin_count[idx]++;
                if (last) begin
                    // The first bin holding a strictly greater count wins the scan.
                    best    = 0;
                    dom_bin = 0;
                    for (int i = 0; i < BIN_COUNT; i++) begin
                        if (bin_count[i] > best) begin
                            best    = bin_count[i];
                            dom_bin = i;
                        end
                    end
                    dom_r = dom_bin >> (2 * AXIS_BITS);
                    dom_g = (dom_bin >> AXIS_BITS) & ((1 << AXIS_BITS) - 1);
                    dom_b = dom_bin & ((1 << AXIS_BITS) - 1);
                end
            end else begin
                pix_dist = chan_gap(dom_r << BIN_SHIFT, r)
                         + chan_gap(dom_g << BIN_SHIFT, g)
                         + chan_gap(dom_b << BIN_SHIFT, b);
                expected_distance_q.push_back(pix_dist[DIST_BITS-1:0]);
                if (last) clear_counts();
            end
        endfunction

        function string check_distance(logic [DIST_BITS-1:0] got);
            bit [DIST_BITS-1:0] want;
            if (expected_distance_q.size() == 0)
                return $sformatf("distance beat %0d with no pixel pending", got);
            want = expected_distance_q.pop_front();
            if (got !== want)
                return $sformatf("distance %0d, predicted %0d", got, want);
            return "";
        endfunction
    endclass

    distance_predictor predictor;
    int                mismatch_count;
    int                beats_sent;
    int                burst_left;
    int                idle_cycles;
    bit                hold_off_req;

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Builds the stored word from channel values; r is the raw 6-bit field.
    function automatic logic [15:0] pack_pixel(logic [4:0] b, logic [5:0] r, logic [4:0] g);
        logic [15:0] s;
        s = {b, r, g};
        return {s[7:0], s[15:8]};
    endfunction

    // A pixel somewhere inside the given bin, with random low bits.
    function automatic logic [15:0] bin_pixel(int unsigned rb, int unsigned gb, int unsigned bb);
        logic [5:0] r6;
        logic [4:0] g5, b5;
        r6 = 6'((rb << BIN_SHIFT) | $urandom_range(0, 3));
        if (rb == 7 && $urandom_range(0, 1) == 1) r6 = 6'($urandom_range(28, 63));
        g5 = 5'((gb << BIN_SHIFT) | $urandom_range(0, 3));
        b5 = 5'((bb << BIN_SHIFT) | $urandom_range(0, 3));
        return pack_pixel(b5, r6, g5);
    endfunction

    // Between bursts the sender may drop valid and scramble the idle payload.
    task automatic pace_sender();
        int gap;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_valid <= 1'b0;
                i_func  <= 1'($urandom);
                i_pixel <= 16'($urandom);
                i_last  <= 1'($urandom);
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic send_beat(logic func, logic [15:0] pixel, logic last);
        i_valid <= 1'b1;
        i_func  <= func;
        i_pixel <= pixel;
        i_last  <= last;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        predictor.note_beat(func, pixel, last);
        beats_sent++;
        pace_sender();
    endtask

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: cycles through stall patterns, plus one long hold-off on request.
    initial begin : sink
        int  mode, mode_left, hold_left, tick;
        bit  hold_done;
        string msg;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 0;
        tick      = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            tick++;
            if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
                msg = predictor.check_distance(o_distance);
                if (msg != "") report_mismatch(msg);
            end
            if (hold_off_req && !hold_done) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(32, 300);
            end else begin
                mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else begin
                case (mode)
                    0: i_ready <= 1'b1;
                    1: i_ready <= 1'($urandom);
                    2: i_ready <= ($urandom_range(0, 3) == 0);
                    default: i_ready <= (tick % 8 < 5);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid === 1'b1 && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin : stimulus
        int          frame_no, kind, n, n_pal, k, random_start;
        int unsigned pal_r [4];
        int unsigned pal_g [4];
        int unsigned pal_b [4];
        logic [15:0] px;

        predictor      = new();
        mismatch_count = 0;
        beats_sent     = 0;
        burst_left     = 0;
        hold_off_req   = 0;
        frame_no       = 0;
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_func  <= FUNC_ACC;
        i_pixel <= '0;
        i_last  <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Map beats before any scan measure against the reset bin, including
        // the clamp of the red field and the largest distance.
        send_beat(FUNC_MAP, 16'h0000, 1'b0);
        send_beat(FUNC_MAP, 16'hFFFF, 1'b0);
        send_beat(FUNC_MAP, pack_pixel(5'd0, 6'd32, 5'd0), 1'b0);
        send_beat(FUNC_MAP, pack_pixel(5'd31, 6'd31, 5'd31), 1'b0);
        send_beat(FUNC_MAP, pack_pixel(5'd0, 6'd63, 5'd0), 1'b1);

        // Equal counts: the bin earlier in r, g, b order must win.
        send_beat(FUNC_ACC, bin_pixel(5, 1, 2), 1'b0);
        send_beat(FUNC_ACC, bin_pixel(2, 6, 0), 1'b0);
        send_beat(FUNC_ACC, bin_pixel(5, 1, 2), 1'b0);
        send_beat(FUNC_ACC, bin_pixel(2, 6, 0), 1'b1);
        send_beat(FUNC_MAP, 16'h0000, 1'b0);
        send_beat(FUNC_MAP, 16'hFFFF, 1'b0);
        send_beat(FUNC_MAP, pack_pixel(5'd31, 6'd0, 5'd31), 1'b1);

        // A second accumulate pass with no map pass between keeps the counts,
        // so the later bin only draws level and the earlier one stays dominant.
        for (k = 0; k < 3; k++) send_beat(FUNC_ACC, bin_pixel(1, 1, 1), 1'b0);
        send_beat(FUNC_ACC, bin_pixel(3, 0, 0), 1'b0);
        send_beat(FUNC_ACC, bin_pixel(3, 0, 0), 1'b1);
        send_beat(FUNC_ACC, bin_pixel(3, 0, 0), 1'b1);
        send_beat(FUNC_MAP, 16'h0000, 1'b0);
        send_beat(FUNC_MAP, 16'($urandom), 1'b1);

        random_start = beats_sent;
        while (beats_sent < random_start + RANDOM_BEATS) begin
            frame_no++;
            kind = (frame_no == 3) ? 0 : $urandom_range(0, 9);
            if (kind <= 6) begin
                n_pal = $urandom_range(1, 4);
                for (k = 0; k < n_pal; k++) begin
                    pal_r[k] = $urandom_range(0, 7);
                    pal_g[k] = $urandom_range(0, 7);
                    pal_b[k] = $urandom_range(0, 7);
                end
                n = $urandom_range(1, 48);
                for (k = 0; k < n; k++) begin
                    kind = $urandom_range(0, n_pal - 1);
                    px = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                     : bin_pixel(pal_r[kind], pal_g[kind],
                                                                 pal_b[kind]);
                    send_beat(FUNC_ACC, px, k == n - 1);
                end
                // One map pass runs into a long receiver hold-off so that the
                // block backs up and refuses input.
                if (frame_no == 3) begin
                    hold_off_req <= 1'b1;
                    n = 40;
                end else begin
                    n = $urandom_range(1, 48);
                end
                for (k = 0; k < n; k++) send_beat(FUNC_MAP, 16'($urandom), k == n - 1);
            end else if (kind == 7) begin
                n = $urandom_range(1, 20);
                for (k = 0; k < n; k++) send_beat(FUNC_ACC, 16'($urandom), 1'b0);
            end else if (kind == 8) begin
                n = $urandom_range(1, 10);
                for (k = 0; k < n; k++) send_beat(FUNC_MAP, 16'($urandom), 1'b0);
            end else begin
                n = $urandom_range(1, 20);
                for (k = 0; k < n; k++)
                    send_beat(1'($urandom), 16'($urandom), $urandom_range(0, 5) == 0);
            end
        end
        i_valid <= 1'b0;

        while (predictor.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dcdm_pkg.sv
rtl/dcdm_front.sv
rtl/dcdm_queue.sv
rtl/dcdm_back.sv
rtl/dominant_color_distance_map.sv
tb/dominant_color_distance_map_test.sv
